>>> rtl/jpc_pkg.sv
// ============================================================================
// jpc_pkg : shared types and constants of the joystick polar converter
// widths, transaction structs, csr indexes and the cordic arctangent table
// ============================================================================
package jpc_pkg;

   // geometry of the conversion
   localparam int AXIS_BITS     = 10;
   localparam int CORDIC_STAGES = 16;

   // field widths
   localparam int POS_W      = 10;
   localparam int ANGLE_W    = 15;
   localparam int MAG_W      = 16;
   localparam int DZ_W       = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // internal widths
   localparam int SPAN_W      = (AXIS_BITS > POS_W) ? AXIS_BITS : POS_W;
   localparam int QUO_BITS    = 16;              // q1.15 plus the bit for 1.0
   localparam int NORM_W      = QUO_BITS + 1;    // signed normalized axis
   localparam int SQ_W        = 2 * QUO_BITS - 1;
   localparam int SUM_W       = 2 * QUO_BITS;
   localparam int ROOT_STAGES = SUM_W / 2;
   localparam int VEC_STAGES  = (ROOT_STAGES > CORDIC_STAGES) ? ROOT_STAGES : CORDIC_STAGES;
   localparam int VEC_IDX_W   = $clog2(VEC_STAGES);
   localparam int CORD_W      = NORM_W + 8 + 2;
   localparam int ZW          = 32;
   localparam int ANG_FRAC    = 22;
   localparam int ANG_SHIFT   = ANG_FRAC - 6;
   localparam int ANG_RAW_W   = ZW - ANG_SHIFT;
   localparam int ATAN_DEPTH  = 24;
   localparam int ATAN_IDX_W  = $clog2(ATAN_DEPTH);

   localparam int ONE_Q15   = 32768;
   localparam int FULL_TURN = 23040;

   localparam logic signed [ZW-1:0] DEG180    = ZW'(180 << ANG_FRAC);
   localparam logic signed [ZW-1:0] ANG_ROUND = ZW'(1 << (ANG_FRAC - 7));

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_REST    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_Y_REST    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE = CSR_IDX_W'(2);

   localparam logic [POS_W-1:0] X_REST_RST    = POS_W'(507);
   localparam logic [POS_W-1:0] Y_REST_RST    = POS_W'(503);
   localparam logic [DZ_W-1:0]  DEAD_ZONE_RST = DZ_W'(2621);

   // atan(2^-i) in 2^-22 degree
   localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_DEPTH] = '{
      32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
      32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
      32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
      32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
      32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
      32'sd229,       32'sd115,       32'sd57,       32'sd29
   };

   typedef struct packed {
      logic [POS_W-1:0] x_pos;
      logic [POS_W-1:0] y_pos;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [MAG_W-1:0]   magnitude;
   } rsp_type;

   // one axis inside the normalizing divider
   typedef struct packed {
      logic [SPAN_W:0]     rem;
      logic [SPAN_W:0]     dsor;
      logic [QUO_BITS-1:0] dvd;
      logic [QUO_BITS-1:0] quo;
      logic                neg;
      logic                zero;
   } div_lane_type;

   typedef struct packed {
      div_lane_type x;
      div_lane_type y;
   } div_item_type;

   // square root remainder/root plus cordic vector and angle
   typedef struct packed {
      logic [SUM_W-1:0]         v;
      logic [SUM_W-1:0]         r;
      logic signed [CORD_W-1:0] a;
      logic signed [CORD_W-1:0] b;
      logic signed [ZW-1:0]     z;
      logic                     zero;
   } vec_item_type;

endpackage

>>> rtl/jpc_div_cell.sv
// ============================================================================
// jpc_div_cell : one quotient bit of the axis normalizer
// restoring divide step on both axes, registered, with its own handshake
// ============================================================================
module jpc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  jpc_pkg::div_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output jpc_pkg::div_item_type out_item
);
   import jpc_pkg::*;

   logic         valid_ff, valid_in;
   div_item_type item_ff, item_in;

   function automatic div_lane_type div_step(input div_lane_type l);
      div_lane_type    o;
      logic [SPAN_W+1:0] trial;
      logic [SPAN_W+1:0] diff;
      o     = l;
      trial = {l.rem, l.dvd[QUO_BITS-1]};
      diff  = trial - {1'b0, l.dsor};
      o.dvd = {l.dvd[QUO_BITS-2:0], 1'b0};
      if (trial >= {1'b0, l.dsor}) begin
         o.rem = diff[SPAN_W:0];
         o.quo = {l.quo[QUO_BITS-2:0], 1'b1};
      end else begin
         o.rem = trial[SPAN_W:0];
         o.quo = {l.quo[QUO_BITS-2:0], 1'b0};
      end
      return o;
   endfunction

   always_comb begin
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
      item_in  = item_ff;
      if (in_ready && in_valid) begin
         item_in.x = div_step(in_item.x);
         item_in.y = div_step(in_item.y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> rtl/jpc_vec_cell.sv
// ============================================================================
// jpc_vec_cell : one step of square root and cordic vectoring
// digit step of the root and one micro-rotation, registered, with handshake
// ============================================================================
module jpc_vec_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [jpc_pkg::VEC_IDX_W-1:0] stage_idx,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  jpc_pkg::vec_item_type         in_item,
   output logic                          out_valid,
   input  logic                          out_ready,
   output jpc_pkg::vec_item_type         out_item
);
   import jpc_pkg::*;

   logic         valid_ff, valid_in;
   vec_item_type item_ff, item_in;
   vec_item_type step;
   logic [SUM_W-1:0]         rbit;
   logic [SUM_W-1:0]         trial;
   logic signed [CORD_W-1:0] sa, sb;
   logic signed [ZW-1:0]     at;

   always_comb begin
      step  = in_item;
      rbit  = SUM_W'(1) << (SUM_W - 2 - 2 * int'(stage_idx));
      trial = in_item.r + rbit;
      sa    = in_item.a >>> stage_idx;
      sb    = in_item.b >>> stage_idx;
      at    = ATAN_TAB[ATAN_IDX_W'(stage_idx)];
      // root digit
      if (int'(stage_idx) < ROOT_STAGES) begin
         if (in_item.v >= trial) begin
            step.v = in_item.v - trial;
            step.r = (in_item.r >> 1) + rbit;
         end else begin
            step.r = in_item.r >> 1;
         end
      end
      // micro-rotation toward the positive a axis
      if (int'(stage_idx) < CORDIC_STAGES) begin
         if (!in_item.b[CORD_W-1]) begin
            step.a = in_item.a + sb;
            step.b = in_item.b - sa;
            step.z = in_item.z + at;
         end else begin
            step.a = in_item.a - sb;
            step.b = in_item.b + sa;
            step.z = in_item.z - at;
         end
      end
   end

   always_comb begin
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
      item_in  = (in_ready && in_valid) ? step : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> rtl/joystick_polar_convert_unit.sv
// ============================================================================
// joystick_polar_convert_unit : joystick x/y sample to magnitude and angle
// centers and scales each axis, then a pipelined root and cordic give
// q1.15 magnitude and angle in 1/64 degree, clockwise from minus y
// ============================================================================
//
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  ------------------------------
//  req      in   req_valid / req_stall     x_pos, y_pos        (req_type)
//  rsp      out  rsp_valid / rsp_stall     angle, magnitude    (rsp_type)
//  csr      in   csr_valid / csr_ready     csr_index, csr_data
//
//  one transaction per cycle sustained while rsp_stall is low; the path runs
//  through the prep stage, the row of divider cells, the norm, sq and sum
//  stages, the row of root/cordic cells and the fin and out stages
//  every stage holds a valid bit and moves when its downstream neighbor is
//  empty or moving, so bubbles close up while rsp_stall is high
//  req_stall rises only once every stage up to the output holds a transaction
//  reset clears all valid bits and loads the csr reset values; no clearing pass
//
module joystick_polar_convert_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  jpc_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output jpc_pkg::rsp_type                rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [jpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [jpc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import jpc_pkg::*;

   // squares and cordic start vector
   typedef struct packed {
      logic [SQ_W-1:0]          sqx;
      logic [SQ_W-1:0]          sqy;
      logic signed [CORD_W-1:0] a;
      logic signed [CORD_W-1:0] b;
      logic signed [ZW-1:0]     z;
      logic                     zero;
   } sq_item_type;

   // rounded magnitude and angle before the dead zone and wrap
   typedef struct packed {
      logic [MAG_W-1:0]            mag;
      logic signed [ANG_RAW_W-1:0] ang;
      logic                        zero;
   } fin_item_type;

   localparam logic [SPAN_W+1:0]           AXIS_FULL = (SPAN_W + 2)'((1 << AXIS_BITS) - 1);
   localparam logic [SPAN_W-1:0]           AXIS_MASK = SPAN_W'((1 << AXIS_BITS) - 1);
   localparam logic signed [ANG_RAW_W:0]   TURN_S    = (ANG_RAW_W + 1)'(FULL_TURN);

   // ---------------------------------------------------------------------
   // csr registers, to be written only while the pipeline is empty; the block does not enforce it
   // ---------------------------------------------------------------------
   logic [POS_W-1:0] x_rest_ff, x_rest_in;
   logic [POS_W-1:0] y_rest_ff, y_rest_in;
   logic [DZ_W-1:0]  dz_ff, dz_in;

   assign csr_ready = 1'b1;

   always_comb begin
      x_rest_in = x_rest_ff;
      y_rest_in = y_rest_ff;
      dz_in     = dz_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_X_REST:    x_rest_in = csr_data[POS_W-1:0];
            CSR_Y_REST:    y_rest_in = csr_data[POS_W-1:0];
            CSR_DEAD_ZONE: dz_in     = csr_data[DZ_W-1:0];
            default:       ;  // index beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_rest_ff <= X_REST_RST;
         y_rest_ff <= Y_REST_RST;
         dz_ff     <= DEAD_ZONE_RST;
      end else begin
         x_rest_ff <= x_rest_in;
         y_rest_ff <= y_rest_in;
         dz_ff     <= dz_in;
      end
   end

   // ---------------------------------------------------------------------
   // prep stage: offset from rest, span on that side, divider start state
   // the divider computes round(|d| * 32768 / span) as
   // floor((|d| * 65536 + span) / (2 * span)); |d| <= span keeps it in 16 bits
   // ---------------------------------------------------------------------
   function automatic div_lane_type prep_lane(input logic [POS_W-1:0] pos,
                                              input logic [POS_W-1:0] rest);
      div_lane_type             l;
      logic [SPAN_W-1:0]        pos_m;
      logic signed [SPAN_W+1:0] d;
      logic signed [SPAN_W+1:0] span;
      logic signed [SPAN_W+1:0] ad;
      pos_m = SPAN_W'(pos) & AXIS_MASK;
      d     = $signed((SPAN_W + 2)'(pos_m)) - $signed((SPAN_W + 2)'(rest));
      span  = d[SPAN_W+1] ? $signed((SPAN_W + 2)'(rest))
                          : $signed(AXIS_FULL) - $signed((SPAN_W + 2)'(rest));
      ad    = d[SPAN_W+1] ? -d : d;
      l.neg  = d[SPAN_W+1];
      // span at or below zero only comes with a zero offset
      l.zero = (d == '0) || (span <= 0);
      l.rem  = ad[SPAN_W:0];
      l.dsor = {span[SPAN_W-1:0], 1'b0};
      l.dvd  = QUO_BITS'(span[SPAN_W-1:0]);
      l.quo  = '0;
      return l;
   endfunction

   logic         div_valid [QUO_BITS+1];
   logic         div_ready [QUO_BITS+1];
   div_item_type div_item  [QUO_BITS+1];

   logic         prep_valid_ff, prep_valid_in;
   div_item_type prep_ff, prep_in;
   logic         prep_ready;

   always_comb begin
      prep_ready    = !prep_valid_ff || div_ready[0];
      prep_valid_in = prep_ready ? req_valid : prep_valid_ff;
      prep_in       = prep_ff;
      if (prep_ready && req_valid) begin
         prep_in.x = prep_lane(req_payload.x_pos, x_rest_ff);
         prep_in.y = prep_lane(req_payload.y_pos, y_rest_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= prep_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
   end

   assign req_stall   = !prep_ready;
   assign div_valid[0] = prep_valid_ff;
   assign div_item[0]  = prep_ff;

   // ---------------------------------------------------------------------
   // row of divider cells, one quotient bit each
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
      jpc_div_cell u_div_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_ready  (div_ready[g]),
         .in_item   (div_item[g]),
         .out_valid (div_valid[g+1]),
         .out_ready (div_ready[g+1]),
         .out_item  (div_item[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // norm stage: cap at 1.0 and apply the sign
   // ---------------------------------------------------------------------
   function automatic logic signed [NORM_W-1:0] lane_value(input div_lane_type l);
      logic [QUO_BITS-1:0] q;
      q = (l.quo > QUO_BITS'(ONE_Q15)) ? QUO_BITS'(ONE_Q15) : l.quo;
      if (l.zero) begin
         return '0;
      end else if (l.neg) begin
         return -$signed({1'b0, q});
      end else begin
         return $signed({1'b0, q});
      end
   endfunction

   logic                     norm_valid_ff, norm_valid_in;
   logic signed [NORM_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic                     norm_ready;
   logic                     sq_ready;

   always_comb begin
      norm_ready    = !norm_valid_ff || sq_ready;
      norm_valid_in = norm_ready ? div_valid[QUO_BITS] : norm_valid_ff;
      nx_in         = nx_ff;
      ny_in         = ny_ff;
      if (norm_ready && div_valid[QUO_BITS]) begin
         nx_in = lane_value(div_item[QUO_BITS].x);
         ny_in = lane_value(div_item[QUO_BITS].y);
      end
   end

   assign div_ready[QUO_BITS] = norm_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_valid_ff <= 1'b0;
      end else begin
         norm_valid_ff <= norm_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in;
      ny_ff <= ny_in;
   end

   // ---------------------------------------------------------------------
   // sq stage: squares for the root, start vector (-ny, nx) for the cordic
   // a negative first component is turned half a circle up front
   // ---------------------------------------------------------------------
   logic signed [2*NORM_W-1:0] prod_x, prod_y;
   logic signed [CORD_W-1:0]   a0, b0;
   logic                       sq_valid_ff, sq_valid_in;
   sq_item_type                sq_ff, sq_in;
   logic                       sum_ready;

   assign prod_x = nx_ff * nx_ff;
   assign prod_y = ny_ff * ny_ff;
   assign a0     = -(CORD_W'(ny_ff) <<< 8);
   assign b0     = CORD_W'(nx_ff) <<< 8;

   always_comb begin
      sq_ready    = !sq_valid_ff || sum_ready;
      sq_valid_in = sq_ready ? norm_valid_ff : sq_valid_ff;
      sq_in       = sq_ff;
      if (sq_ready && norm_valid_ff) begin
         sq_in.sqx  = prod_x[SQ_W-1:0];
         sq_in.sqy  = prod_y[SQ_W-1:0];
         sq_in.zero = (nx_ff == '0) && (ny_ff == '0);
         if (a0[CORD_W-1]) begin
            sq_in.a = -a0;
            sq_in.b = -b0;
            sq_in.z = DEG180;
         end else begin
            sq_in.a = a0;
            sq_in.b = b0;
            sq_in.z = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   // ---------------------------------------------------------------------
   // sum stage: sum of squares becomes the root remainder
   // ---------------------------------------------------------------------
   logic         vec_valid [VEC_STAGES+1];
   logic         vec_ready [VEC_STAGES+1];
   vec_item_type vec_item  [VEC_STAGES+1];

   logic         sum_valid_ff, sum_valid_in;
   vec_item_type sum_ff, sum_in;

   always_comb begin
      sum_ready    = !sum_valid_ff || vec_ready[0];
      sum_valid_in = sum_ready ? sq_valid_ff : sum_valid_ff;
      sum_in       = sum_ff;
      if (sum_ready && sq_valid_ff) begin
         sum_in.v    = SUM_W'(sq_ff.sqx) + SUM_W'(sq_ff.sqy);
         sum_in.r    = '0;
         sum_in.a    = sq_ff.a;
         sum_in.b    = sq_ff.b;
         sum_in.z    = sq_ff.z;
         sum_in.zero = sq_ff.zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign vec_valid[0] = sum_valid_ff;
   assign vec_item[0]  = sum_ff;

   // ---------------------------------------------------------------------
   // row of root/cordic cells
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < VEC_STAGES; g++) begin : g_vec
      jpc_vec_cell u_vec_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (VEC_IDX_W'(g)),
         .in_valid  (vec_valid[g]),
         .in_ready  (vec_ready[g]),
         .in_item   (vec_item[g]),
         .out_valid (vec_valid[g+1]),
         .out_ready (vec_ready[g+1]),
         .out_item  (vec_item[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // fin stage: round the root to nearest, cap at 1.0, round the angle
   // ---------------------------------------------------------------------
   logic         fin_valid_ff, fin_valid_in;
   fin_item_type fin_ff, fin_in;
   logic         fin_ready;
   logic         out_ready;
   logic [MAG_W:0]       mag_r;
   logic signed [ZW-1:0] z_r;

   always_comb begin
      mag_r = (MAG_W + 1)'(vec_item[VEC_STAGES].r)
            + ((vec_item[VEC_STAGES].v > vec_item[VEC_STAGES].r) ? (MAG_W + 1)'(1)
                                                                  : (MAG_W + 1)'(0));
      z_r   = (vec_item[VEC_STAGES].z + ANG_ROUND) >>> ANG_SHIFT;
   end

   always_comb begin
      fin_ready    = !fin_valid_ff || out_ready;
      fin_valid_in = fin_ready ? vec_valid[VEC_STAGES] : fin_valid_ff;
      fin_in       = fin_ff;
      if (fin_ready && vec_valid[VEC_STAGES]) begin
         fin_in.mag  = (mag_r > (MAG_W + 1)'(ONE_Q15)) ? MAG_W'(ONE_Q15) : mag_r[MAG_W-1:0];
         fin_in.ang  = z_r[ANG_RAW_W-1:0];
         fin_in.zero = vec_item[VEC_STAGES].zero;
      end
   end

   assign vec_ready[VEC_STAGES] = fin_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
   end

   // ---------------------------------------------------------------------
   // output register: dead zone, zero vector and wrap into 0..360 degrees
   // ---------------------------------------------------------------------
   logic                     out_valid_ff, out_valid_in;
   rsp_type                  out_ff, out_in;
   logic signed [ANG_RAW_W:0] ang_w;
   logic signed [ANG_RAW_W:0] ang_wrap;

   always_comb begin
      ang_w = {fin_ff.ang[ANG_RAW_W-1], fin_ff.ang};
      if (ang_w < 0) begin
         ang_wrap = ang_w + TURN_S;
      end else if (ang_w >= TURN_S) begin
         ang_wrap = ang_w - TURN_S;
      end else begin
         ang_wrap = ang_w;
      end
   end

   always_comb begin
      out_ready    = !out_valid_ff || !rsp_stall;
      out_valid_in = out_ready ? fin_valid_ff : out_valid_ff;
      out_in       = out_ff;
      if (out_ready && fin_valid_ff) begin
         if (fin_ff.zero || (fin_ff.mag < dz_ff)) begin
            out_in.angle     = '0;
            out_in.magnitude = '0;
         end else begin
            out_in.angle     = ang_wrap[ANGLE_W-1:0];
            out_in.magnitude = fin_ff.mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

>>> rtl/jpc_port_checker.sv
// ============================================================================
// jpc_port_checker : port level checks of the joystick polar converter
// result ranges, zero result shape and output hold under stall
// ============================================================================
module jpc_port_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  jpc_pkg::rsp_type rsp_payload
);
   import jpc_pkg::*;

   // angle always wrapped below a full turn
   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_payload.angle) < FULL_TURN))
      else $error("angle outside a full turn");

   // magnitude never above 1.0
   a_mag_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_payload.magnitude) <= ONE_Q15))
      else $error("magnitude above 1.0");

   // a zero magnitude always comes with a zero angle
   a_zero_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.magnitude == '0)) |-> (rsp_payload.angle == '0))
      else $error("zero magnitude with nonzero angle");

   // a stalled transaction stays in place
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled transaction changed");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

endmodule

bind joystick_polar_convert_unit jpc_port_checker u_port_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

>>> tb/sv/tb_joystick_polar_convert_unit.sv
// ============================================================================
// tb_joystick_polar_convert_unit : self-checking bench of the polar converter
// drives raw x/y joystick readings through several csr settings and idle
// patterns, predicts magnitude and angle in fixed point and checks every
// result transaction in order against the prediction
// ============================================================================
module tb_joystick_polar_convert_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import jpc_pkg::*;

   // csr index past the last register, writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   localparam longint AXIS_FULL    = (longint'(1) << AXIS_BITS) - 1;
   localparam longint Q15_UNITY    = 32768;
   localparam longint DEG_TURN     = 23040;
   localparam longint Z_HALF_TURN  = longint'(180) << 22;
   localparam int     ARC_STAGES   = 16;
   localparam int     PIPE_LATENCY = 38;
   localparam int     PHASE_COUNT  = 4;
   localparam int     PHASE_ITEMS  = 100;

   // atan(2^-i) in 2^-22 degree
   localparam longint ARC_STEP [ARC_STAGES] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342,
      58671, 29335, 14668, 7334
   };

   // sender idle and receiver stall percentages of each random phase
   localparam int IDLE_PCT  [PHASE_COUNT] = '{0, 52, 0, 31};
   localparam int STALL_PCT [PHASE_COUNT] = '{0, 0, 52, 31};

   // -------------------------------------------------------------------------
   // scoreboard: mirrors the csr contents, predicts each accepted reading
   // and checks result transactions in arrival order
   // -------------------------------------------------------------------------
   class polar_checker;
      logic [POS_W-1:0] x_rest;
      logic [POS_W-1:0] y_rest;
      logic [DZ_W-1:0]  dead_zone;
      rsp_type          pending_polar[$];
      int               readings;
      int               results;
      int               deflected;
      int               reg_writes;
      int               errors;

      function new();
         x_rest     = 507;
         y_rest     = 503;
         dead_zone  = 2621;
         readings   = 0;
         results    = 0;
         deflected  = 0;
         reg_writes = 0;
         errors     = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         reg_writes++;
         case (idx)
            CSR_X_REST:    x_rest = data[POS_W-1:0];
            CSR_Y_REST:    y_rest = data[POS_W-1:0];
            CSR_DEAD_ZONE: dead_zone = data[DZ_W-1:0];
            default: ;
         endcase
      endfunction

      // offset from rest scaled to q1.15 by the span on its side
      function longint scale_axis(logic [POS_W-1:0] pos, logic [POS_W-1:0] rest);
         longint d, span, ad, n;
         d    = longint'(pos) - longint'(rest);
         span = (d >= 0) ? AXIS_FULL - longint'(rest) : longint'(rest);
         ad   = (d < 0) ? -d : d;
         if (ad == 0)
            return 0;
         if (span <= 0) begin
            n = Q15_UNITY;
         end else begin
            n = (ad * 65536 + span) / (2 * span);
            if (n > Q15_UNITY)
               n = Q15_UNITY;
         end
         return (d < 0) ? -n : n;
      endfunction

      // integer square root rounded to nearest
      function longint round_root(longint s);
         longint r, probe, v;
         r     = 0;
         v     = s;
         probe = longint'(1) << 40;
         while (probe > v)
            probe = probe >> 2;
         while (probe != 0) begin
            if (v >= r + probe) begin
               v = v - (r + probe);
               r = (r >> 1) + probe;
            end else begin
               r = r >> 1;
            end
            probe = probe >> 2;
         end
         if (s - r * r > r)
            r++;
         return r;
      endfunction

      // vectoring cordic on (-ny, nx), angle rounded to 1/64 degree
      function longint cordic_heading(longint nx, longint ny);
         longint a, b, z, na, nb, h;
         a = -ny * 256;
         b = nx * 256;
         z = 0;
         if (a < 0) begin
            a = -a;
            b = -b;
            z = Z_HALF_TURN;
         end
         for (int i = 0; i < ARC_STAGES; i++) begin
            if (b >= 0) begin
               na = a + (b >>> i);
               nb = b - (a >>> i);
               z  = z + ARC_STEP[i];
            end else begin
               na = a - (b >>> i);
               nb = b + (a >>> i);
               z  = z - ARC_STEP[i];
            end
            a = na;
            b = nb;
         end
         h = (z + (longint'(1) << 15)) >>> 16;
         if (h < 0)
            h = h + DEG_TURN;
         if (h >= DEG_TURN)
            h = h - DEG_TURN;
         return h;
      endfunction

      function rsp_type predict_polar(req_type rd);
         rsp_type res;
         longint  nx, ny, mag, ang;
         nx  = scale_axis(rd.x_pos, x_rest);
         ny  = scale_axis(rd.y_pos, y_rest);
         mag = round_root(nx * nx + ny * ny);
         ang = 0;
         if (mag > Q15_UNITY)
            mag = Q15_UNITY;
         // dead zone and the zero vector both give an all-zero result
         if (mag < longint'(dead_zone) || (nx == 0 && ny == 0)) begin
            mag = 0;
         end else begin
            ang = cordic_heading(nx, ny);
         end
         res.angle     = ANGLE_W'(ang);
         res.magnitude = MAG_W'(mag);
         return res;
      endfunction

      function void note_reading(req_type rd);
         readings++;
         pending_polar.push_back(predict_polar(rd));
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_res;
         results++;
         if (got.magnitude != 0)
            deflected++;
         if (pending_polar.size() == 0) begin
            errors++;
            $display("%0t ns: result with none expected, got angle %0d magnitude %0d",
                     $time, got.angle, got.magnitude);
            return;
         end
         exp_res = pending_polar.pop_front();
         if (got.angle !== exp_res.angle) begin
            errors++;
            $display("%0t ns: angle mismatch, expected %0d, got %0d",
                     $time, exp_res.angle, got.angle);
         end
         if (got.magnitude !== exp_res.magnitude) begin
            errors++;
            $display("%0t ns: magnitude mismatch, expected %0d, got %0d",
                     $time, exp_res.magnitude, got.magnitude);
         end
      endfunction

      function int pending();
         return pending_polar.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block ports
   // -------------------------------------------------------------------------
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_X_REST;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   int idle_pct  = 0;
   int stall_pct = 0;

   polar_checker chk = new();

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   joystick_polar_convert_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // receiver back-pressure, random per cycle at the phase's rate
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // monitor: every handshake is taken from the values seen at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            chk.set_register(csr_index, csr_data);
         if (req_valid && !req_stall)
            chk.note_reading(req_payload);
         if (rsp_valid && !rsp_stall)
            chk.check_result(rsp_payload);
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------

   // one csr write; valid drops after the accepting edge
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one request transaction, with an optional idle gap in front of it
   task automatic send_reading(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6))
            @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_payload.x_pos <= x;
      req_payload.y_pos <= y;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // stop sending and wait for every predicted result to come back
   // one edge first so the last accepted reading is already noted
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chk.pending() != 0)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
   endtask

   // reading close to a rest value, clamped to the axis
   function automatic logic [POS_W-1:0] near_rest(logic [POS_W-1:0] rest);
      int v;
      v = int'(rest) + int'($urandom_range(80)) - 40;
      if (v < 0)
         v = 0;
      if (v > int'(AXIS_FULL))
         v = int'(AXIS_FULL);
      return POS_W'(v);
   endfunction

   function automatic logic [POS_W-1:0] extreme_pos(logic [POS_W-1:0] rest);
      case ($urandom_range(3))
         0:       return '0;
         1:       return POS_W'(AXIS_FULL);
         2:       return rest;
         default: return POS_W'($urandom_range(AXIS_FULL));
      endcase
   endfunction

   // half uniform readings, plus readings around the rest point and edges
   function automatic req_type random_reading();
      req_type     rd;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         rd.x_pos = POS_W'($urandom_range(AXIS_FULL));
         rd.y_pos = POS_W'($urandom_range(AXIS_FULL));
      end else if (pick < 75) begin
         rd.x_pos = near_rest(chk.x_rest);
         rd.y_pos = near_rest(chk.y_rest);
      end else begin
         rd.x_pos = extreme_pos(chk.x_rest);
         rd.y_pos = extreme_pos(chk.y_rest);
      end
      return rd;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_rest();
      logic [POS_W-1:0] rest;
      if ($urandom_range(99) < 80)
         rest = POS_W'($urandom_range(620, 400));
      else
         rest = POS_W'($urandom_range(AXIS_FULL));
      // junk in the upper bits must be dropped by the block
      return {6'($urandom_range(63)), rest};
   endfunction

   // new csr setting for a random phase; the pipeline is empty here
   task automatic pick_setting();
      int unsigned pick;
      logic [CSR_DATA_W-1:0] dz;
      pick = $urandom_range(99);
      if (pick < 15)
         dz = '0;
      else if (pick < 85)
         dz = CSR_DATA_W'($urandom_range(6000));
      else if (pick < 95)
         dz = CSR_DATA_W'($urandom_range(32768, 6000));
      else
         dz = CSR_DATA_W'($urandom_range(65535, 32769));
      write_csr(CSR_X_REST, random_rest());
      write_csr(CSR_Y_REST, random_rest());
      write_csr(CSR_DEAD_ZONE, dz);
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      req_type rd;

      repeat (12)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: rest point, corners, the four axis directions
      send_reading(507, 503);
      send_reading(0, 0);
      send_reading(1023, 1023);
      send_reading(0, 1023);
      send_reading(1023, 0);
      send_reading(507, 0);
      send_reading(1023, 503);
      send_reading(507, 1023);
      send_reading(0, 503);
      // just left of minus y, angle wraps to just under a full turn
      send_reading(506, 0);
      // just inside and just outside the dead zone
      send_reading(520, 503);
      send_reading(550, 503);
      drain();

      // no dead zone: zero vector and the smallest deflection
      write_csr(CSR_DEAD_ZONE, '0);
      send_reading(507, 503);
      send_reading(508, 503);
      drain();

      // rest at the axis ends; y write carries junk above the field
      write_csr(CSR_X_REST, '0);
      write_csr(CSR_Y_REST, '1);
      send_reading(0, 1023);
      send_reading(1023, 0);
      send_reading(0, 0);
      drain();
      write_csr(CSR_X_REST, CSR_DATA_W'(AXIS_FULL));
      write_csr(CSR_Y_REST, '0);
      send_reading(1023, 0);
      send_reading(0, 1023);
      send_reading(512, 1023);
      drain();

      // dead zone exactly at full scale still lets full deflection through
      write_csr(CSR_DEAD_ZONE, CSR_DATA_W'(Q15_UNITY));
      send_reading(1023, 1023);
      send_reading(0, 0);
      drain();

      // dead zone above full scale blanks everything
      write_csr(CSR_DEAD_ZONE, '1);
      send_reading(0, 0);
      drain();

      // back to the reset setting, then a write to the spare index
      write_csr(CSR_X_REST, 507);
      write_csr(CSR_Y_REST, 503);
      write_csr(CSR_DEAD_ZONE, 2621);
      write_csr(CSR_SPARE, 16'h1234);
      send_reading(1023, 1023);
      send_reading(600, 400);
      drain();

      // random phases with their own setting and idle pattern
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         pick_setting();
         idle_pct  = IDLE_PCT[ph];
         stall_pct = STALL_PCT[ph];
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // sender holds off mid-phase until the pipeline is empty
            if (k == PHASE_ITEMS / 2 && ph % 2 == 1)
               drain();
            rd = random_reading();
            send_reading(rd.x_pos, rd.y_pos);
         end
         drain();
      end

      idle_pct  = 0;
      stall_pct = 0;
      repeat (2 * PIPE_LATENCY)
         @(posedge clock);

      $display("covered %0d readings over %0d csr writes, %0d results checked",
               chk.readings, chk.reg_writes, chk.results);
      $display("%0d results outside the dead zone, %0d mismatches",
               chk.deflected, chk.errors);
      if (chk.errors == 0 && chk.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", chk.pending());
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
rtl/jpc_pkg.sv
rtl/jpc_div_cell.sv
rtl/jpc_vec_cell.sv
rtl/joystick_polar_convert_unit.sv
rtl/jpc_port_checker.sv
tb/sv/tb_joystick_polar_convert_unit.sv
